// ===== rtl/core/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// shared constants, codes and types of the k-means clustering engine
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int unsigned MAX_POINTS   = 1024;
    localparam int unsigned MAX_CLUSTERS = 16;
    localparam int unsigned MAX_DIMS     = 16;
    localparam int unsigned COORD_W      = 16;

    localparam int unsigned PID_W  = $clog2(MAX_POINTS);
    localparam int unsigned DIM_W  = $clog2(MAX_DIMS);
    localparam int unsigned CID_W  = $clog2(MAX_CLUSTERS);
    localparam int unsigned NP_W   = 11;
    localparam int unsigned NK_W   = 5;
    localparam int unsigned ND_W   = 5;
    localparam int unsigned IT_W   = 8;
    localparam int unsigned REQ_W  = 3;
    localparam int unsigned KIND_W = 2;

    localparam int unsigned SQ_W    = 2 * (COORD_W + 1);
    localparam int unsigned DIST_W  = SQ_W + DIM_W;
    localparam int unsigned SUM_W   = COORD_W + PID_W + 1;
    localparam int unsigned CNT_W   = PID_W + 1;
    localparam int unsigned STEP_W  = $clog2(SUM_W);

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam int unsigned DRAIN_CYC = 2 * MAX_CLUSTERS + 2;
    localparam int unsigned DRN_W     = $clog2(DRAIN_CYC);

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_P = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_C = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RUN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ_C = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_A = 3'd4;

    // response kinds
    localparam logic [KIND_W-1:0] RESP_RUN    = 2'd0;
    localparam logic [KIND_W-1:0] RESP_CENT   = 2'd1;
    localparam logic [KIND_W-1:0] RESP_ASSIGN = 2'd2;

    // register indexes
    localparam logic [1:0] REG_NUM_POINTS   = 2'd0;
    localparam logic [1:0] REG_NUM_CLUSTERS = 2'd1;
    localparam logic [1:0] REG_NUM_DIMS     = 2'd2;
    localparam logic [1:0] REG_MAX_ITER     = 2'd3;

    // cell modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_DIST  = 2'd1;
    localparam logic [1:0] MODE_ACCUM = 2'd2;

    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       last;
        logic                       nodim;
        logic [DIM_W-1:0]           dim;
        logic [PID_W-1:0]           pid;
        logic [CID_W-1:0]           cid;
        logic signed [COORD_W-1:0]  coord;
        logic [DIST_W-1:0]          best_d;
        logic [CID_W-1:0]           best_id;
    } t_tok;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [NK_W-1:0]            k;
        logic [ND_W-1:0]            d;
        logic                       clr_sums;
        logic                       div_start;
        logic [DIM_W-1:0]           rd_dim;
        logic                       wr_en;
        logic [CID_W-1:0]           wr_row;
        logic [DIM_W-1:0]           wr_dim;
        logic signed [COORD_W-1:0]  wr_data;
    } t_cell_ctl;

endpackage

// ===== rtl/core/kmc_req_if.sv =====
// ----------------------------------------------------------------------------
// kmc_req_if
// request channel: valid/ready handshake with one request item
// ----------------------------------------------------------------------------
interface kmc_req_if;
    import kmc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic [PID_W-1:0]           row_index;
    logic [DIM_W-1:0]           dim_index;
    logic signed [COORD_W-1:0]  coord_value;

    modport source (
        output valid, req_type, row_index, dim_index, coord_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, row_index, dim_index, coord_value,
        output ready
    );
endinterface

// ===== rtl/core/kmc_resp_if.sv =====
// ----------------------------------------------------------------------------
// kmc_resp_if
// response channel: valid/ready handshake with one response item
// ----------------------------------------------------------------------------
interface kmc_resp_if;
    import kmc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          resp_kind;
    logic signed [COORD_W-1:0]  data_value;
    logic [CID_W-1:0]           cluster_id;
    logic [IT_W-1:0]            iterations_run;
    logic                       converged;

    modport source (
        output valid, resp_kind, data_value, cluster_id, iterations_run, converged,
        input  ready
    );
    modport sink (
        input  valid, resp_kind, data_value, cluster_id, iterations_run, converged,
        output ready
    );
endinterface

// ===== rtl/core/kmc_cell.sv =====
// ----------------------------------------------------------------------------
// kmc_cell
// one cluster cell: holds a centroid, its sums and member count, measures
// the squared distance of passing points, accumulates members and divides
// ----------------------------------------------------------------------------
module kmc_cell #(
    parameter int unsigned CELL_ID = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kmc_pkg::t_cell_ctl                 i_ctl,
    input  kmc_pkg::t_tok                      i_tok,
    output kmc_pkg::t_tok                      o_tok,
    output logic signed [kmc_pkg::COORD_W-1:0] o_rd_coord,
    output logic                               o_busy
);
    import kmc_pkg::*;

    localparam logic [CID_W-1:0] MY_ID = CID_W'(CELL_ID);

    logic signed [COORD_W-1:0] r_cent [MAX_DIMS];
    logic signed [SUM_W-1:0]   r_sum  [MAX_DIMS];
    logic [CNT_W-1:0]          r_cnt;

    t_tok                      r_a_tok;
    logic [SQ_W-1:0]           r_a_sq;
    t_tok                      r_b_tok;
    logic [DIST_W-1:0]         r_acc;

    logic                      r_dv_busy;
    logic                      r_dv_ld;
    logic [DIM_W-1:0]          r_dv_dim;
    logic [STEP_W-1:0]         r_dv_step;
    logic                      r_dv_neg;
    logic [CNT_W:0]            r_rem;
    logic [SUM_W-1:0]          r_quo;

    logic [DIM_W-1:0]          w_c_addr;
    logic signed [COORD_W-1:0] w_cent_rd;
    logic signed [COORD_W:0]   w_diff;
    logic [COORD_W:0]          w_mag;
    logic [SQ_W-1:0]           w_sq;
    logic [DIST_W-1:0]         w_dist;
    logic                      w_active;
    t_tok                      n_b_tok;
    logic [DIM_W-1:0]          w_s_addr;
    logic signed [SUM_W-1:0]   w_sum_rd;
    logic signed [SUM_W-1:0]   w_coord_x;
    logic                      w_acc_hit;
    logic [CNT_W:0]            w_try;
    logic                      w_ge;
    logic [CNT_W:0]            n_rem;
    logic [SUM_W-1:0]          n_quo;
    logic [COORD_W-1:0]        w_q_res;

    // distance path
    assign w_c_addr   = (i_ctl.mode == MODE_DIST) ? i_tok.dim : i_ctl.rd_dim;
    assign w_cent_rd  = r_cent[w_c_addr];
    assign o_rd_coord = w_cent_rd;
    assign w_diff     = $signed({i_tok.coord[COORD_W-1], i_tok.coord})
                      - $signed({w_cent_rd[COORD_W-1], w_cent_rd});
    assign w_mag      = w_diff[COORD_W] ? (COORD_W+1)'(-w_diff) : w_diff;
    assign w_sq       = SQ_W'(w_mag) * SQ_W'(w_mag);

    assign w_dist   = r_a_tok.first ? DIST_W'(r_a_sq) : r_acc + DIST_W'(r_a_sq);
    assign w_active = NK_W'(CELL_ID) < i_ctl.k;

    always_comb begin
        n_b_tok = r_a_tok;
        if (i_ctl.mode == MODE_DIST && r_a_tok.valid && r_a_tok.last) begin
            if (CELL_ID == 0 || (w_active && w_dist < r_a_tok.best_d)) begin
                n_b_tok.best_d  = w_dist;
                n_b_tok.best_id = MY_ID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok <= '0;
            r_b_tok <= '0;
        end else begin
            r_a_tok <= i_tok;
            r_b_tok <= n_b_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sq <= i_tok.nodim ? '0 : w_sq;
        if (r_a_tok.valid && i_ctl.mode == MODE_DIST) begin
            r_acc <= w_dist;
        end
    end

    assign o_tok = r_b_tok;

    // member accumulation
    assign w_s_addr  = (i_ctl.mode == MODE_ACCUM) ? r_a_tok.dim : r_dv_dim;
    assign w_sum_rd  = r_sum[w_s_addr];
    assign w_coord_x = SUM_W'(r_a_tok.coord);
    assign w_acc_hit = i_ctl.mode == MODE_ACCUM && r_a_tok.valid && r_a_tok.cid == MY_ID;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_sums) begin
            for (int j = 0; j < MAX_DIMS; j++) begin
                r_sum[j] <= '0;
            end
            r_cnt <= '0;
        end else if (w_acc_hit) begin
            if (!r_a_tok.nodim) begin
                r_sum[w_s_addr] <= w_sum_rd + w_coord_x;
            end
            if (r_a_tok.last) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    assign w_try   = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign w_ge    = w_try >= {1'b0, r_cnt};
    assign n_rem   = w_ge ? w_try - {1'b0, r_cnt} : w_try;
    assign n_quo   = {r_quo[SUM_W-2:0], w_ge};
    assign w_q_res = r_dv_neg ? COORD_W'(-n_quo[COORD_W-1:0]) : n_quo[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_ld   <= 1'b0;
            r_dv_dim  <= '0;
            r_dv_step <= '0;
        end else if (i_ctl.div_start) begin
            r_dv_busy <= r_cnt != '0 && w_active && i_ctl.d != '0;
            r_dv_ld   <= 1'b1;
            r_dv_dim  <= '0;
        end else if (r_dv_busy) begin
            if (r_dv_ld) begin
                r_dv_ld   <= 1'b0;
                r_dv_step <= '0;
            end else if (r_dv_step == STEP_W'(SUM_W - 1)) begin
                if (ND_W'(r_dv_dim) + ND_W'(1) == i_ctl.d) begin
                    r_dv_busy <= 1'b0;
                end else begin
                    r_dv_dim <= r_dv_dim + DIM_W'(1);
                    r_dv_ld  <= 1'b1;
                end
            end else begin
                r_dv_step <= r_dv_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv_busy) begin
            if (r_dv_ld) begin
                r_dv_neg <= w_sum_rd[SUM_W-1];
                r_quo    <= w_sum_rd[SUM_W-1] ? SUM_W'(-w_sum_rd) : w_sum_rd;
                r_rem    <= '0;
            end else begin
                r_quo <= n_quo;
                r_rem <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_row == MY_ID) begin
            r_cent[i_ctl.wr_dim] <= i_ctl.wr_data;
        end else if (r_dv_busy && !r_dv_ld && r_dv_step == STEP_W'(SUM_W - 1)) begin
            r_cent[r_dv_dim] <= w_q_res;
        end
    end

    assign o_busy = r_dv_busy;

endmodule

// ===== rtl/core/kmeans_lloyd_clustering.sv =====
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering
// k-means engine (Lloyd passes) built as a chain of cluster cells
//
//   channel   dir   handshake            carries
//   i_req     in    valid/ready          load, run and read requests
//   o_resp    out   valid/ready          run status, centroid, assignment
//   apb       in    psel/penable/pready  four configuration registers
//
// load items are accepted back to back, read items too while o_resp takes them
// a run makes per pass an assignment sweep and, unless nothing changed, an
// accumulation sweep and a divide in the cell dividers
// the rate of a run is set by the single point memory read port
// reset clears control state only; no memory is swept
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kmc_req_if.sink                       i_req,
    kmc_resp_if.source                    o_resp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kmc_pkg::PADDR_W-1:0]   paddr,
    input  logic [kmc_pkg::PDATA_W-1:0]   pwdata,
    output logic [kmc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import kmc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_A_ISS = 4'd1;
    localparam logic [3:0] ST_A_DRN = 4'd2;
    localparam logic [3:0] ST_A_END = 4'd3;
    localparam logic [3:0] ST_S_ISS = 4'd4;
    localparam logic [3:0] ST_S_DRN = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_DIV_W = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [NP_W-1:0]  r_num_points;
    logic [NK_W-1:0]  r_num_clusters;
    logic [ND_W-1:0]  r_num_dims;
    logic [IT_W-1:0]  r_max_iter;

    logic [NP_W-1:0]  w_n;
    logic [NK_W-1:0]  w_k;
    logic [ND_W-1:0]  w_d;
    logic [ND_W-1:0]  w_d_iss;

    logic [3:0]       r_state;
    logic [IT_W-1:0]  r_iters;
    logic             r_conv;
    logic             r_changed;
    logic [NP_W-1:0]  r_fill;
    logic [NP_W-1:0]  r_pi;
    logic [DIM_W-1:0] r_dj;
    logic [DRN_W-1:0] r_drn;

    logic             r_iss_valid;
    logic             r_iss_first;
    logic             r_iss_last;
    logic             r_iss_nodim;
    logic [DIM_W-1:0] r_iss_dim;
    logic [PID_W-1:0] r_iss_pid;

    logic signed [COORD_W-1:0] r_pmem [MAX_POINTS*MAX_DIMS];
    logic signed [COORD_W-1:0] r_pmem_q;
    logic [CID_W-1:0]          r_amem [MAX_POINTS];
    logic [CID_W-1:0]          r_amem_q;

    logic                      r_p_valid;
    logic [KIND_W-1:0]         r_p_kind;
    logic signed [COORD_W-1:0] r_p_val;
    logic [PID_W-1:0]          r_p_row;

    logic                      r_o_valid;
    logic [KIND_W-1:0]         r_o_kind;
    logic signed [COORD_W-1:0] r_o_val;
    logic [CID_W-1:0]          r_o_cid;
    logic [IT_W-1:0]           r_o_iters;
    logic                      r_o_conv;

    logic             w_in_ready;
    logic             w_in_acc;
    logic             w_o_free;
    logic             w_issue;
    logic             w_last_dim;
    logic             w_last_pt;
    logic             w_amem_we;
    logic             w_amem_re;
    logic [PID_W-1:0] w_amem_ra;
    logic             w_busy;
    logic             w_is_read;
    logic             w_row_cent;

    t_cell_ctl                 w_ctl;
    t_tok                      w_tok [MAX_CLUSTERS+1];
    logic signed [COORD_W-1:0] w_rd_coord [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0]   w_cell_busy;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= NP_W'(1024);
            r_num_clusters <= NK_W'(16);
            r_num_dims     <= ND_W'(16);
            r_max_iter     <= IT_W'(25);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_NUM_POINTS:   r_num_points   <= pwdata[NP_W-1:0];
                REG_NUM_CLUSTERS: r_num_clusters <= pwdata[NK_W-1:0];
                REG_NUM_DIMS:     r_num_dims     <= pwdata[ND_W-1:0];
                REG_MAX_ITER:     r_max_iter     <= pwdata[IT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_POINTS:   prdata = PDATA_W'(r_num_points);
            REG_NUM_CLUSTERS: prdata = PDATA_W'(r_num_clusters);
            REG_NUM_DIMS:     prdata = PDATA_W'(r_num_dims);
            REG_MAX_ITER:     prdata = PDATA_W'(r_max_iter);
            default:          prdata = '0;
        endcase
    end

    assign w_n = (r_num_points > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : r_num_points;
    assign w_k = (r_num_clusters == '0) ? NK_W'(1)
               : (r_num_clusters > NK_W'(MAX_CLUSTERS)) ? NK_W'(MAX_CLUSTERS)
               : r_num_clusters;
    assign w_d = (r_num_dims > ND_W'(MAX_DIMS)) ? ND_W'(MAX_DIMS) : r_num_dims;
    assign w_d_iss = (w_d == '0) ? ND_W'(1) : w_d;

    // handshake
    assign w_o_free   = !r_o_valid || o_resp.ready;
    assign w_in_ready = (r_state == ST_IDLE) && (!r_p_valid || w_o_free);
    assign w_in_acc   = i_req.valid && w_in_ready;
    assign i_req.ready = w_in_ready;
    assign w_is_read  = i_req.req_type == REQ_READ_C || i_req.req_type == REQ_READ_A;
    assign w_row_cent = i_req.row_index < PID_W'(MAX_CLUSTERS);

    // point issue
    assign w_issue    = (r_state == ST_A_ISS || r_state == ST_S_ISS) && w_n != '0;
    assign w_last_dim = ND_W'(r_dj) == w_d_iss - ND_W'(1);
    assign w_last_pt  = r_pi == w_n - NP_W'(1);

    assign w_amem_we = w_tok[MAX_CLUSTERS].valid && w_tok[MAX_CLUSTERS].last
                     && (r_state == ST_A_ISS || r_state == ST_A_DRN);
    assign w_amem_re = w_issue || (w_in_acc && i_req.req_type == REQ_READ_A);
    assign w_amem_ra = w_issue ? r_pi[PID_W-1:0] : i_req.row_index;

    assign w_busy = |w_cell_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_iters   <= '0;
            r_conv    <= 1'b0;
            r_changed <= 1'b0;
            r_fill    <= '0;
            r_pi      <= '0;
            r_dj      <= '0;
            r_drn     <= '0;
        end else begin
            if (w_amem_we && w_tok[MAX_CLUSTERS].best_id != w_tok[MAX_CLUSTERS].cid) begin
                r_changed <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_req.req_type == REQ_RUN) begin
                        r_fill    <= '0;
                        r_conv    <= 1'b0;
                        r_changed <= 1'b0;
                        r_pi      <= '0;
                        r_dj      <= '0;
                        if (r_max_iter == '0) begin
                            r_iters <= '0;
                            r_state <= ST_FIN;
                        end else begin
                            r_iters <= IT_W'(1);
                            r_state <= ST_A_ISS;
                        end
                    end
                end
                ST_A_ISS, ST_S_ISS: begin
                    if (w_n == '0 || (w_last_dim && w_last_pt)) begin
                        r_pi    <= '0;
                        r_dj    <= '0;
                        r_drn   <= '0;
                        r_state <= (r_state == ST_A_ISS) ? ST_A_DRN : ST_S_DRN;
                    end else if (w_last_dim) begin
                        r_dj <= '0;
                        r_pi <= r_pi + NP_W'(1);
                    end else begin
                        r_dj <= r_dj + DIM_W'(1);
                    end
                end
                ST_A_DRN, ST_S_DRN: begin
                    if (r_drn == DRN_W'(DRAIN_CYC - 1)) begin
                        r_state <= (r_state == ST_A_DRN) ? ST_A_END : ST_DIV;
                    end else begin
                        r_drn <= r_drn + DRN_W'(1);
                    end
                end
                ST_A_END: begin
                    r_fill <= w_n;
                    if (!r_changed) begin
                        r_conv  <= 1'b1;
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_S_ISS;
                    end
                end
                ST_DIV: begin
                    r_state <= ST_DIV_W;
                end
                ST_DIV_W: begin
                    if (!w_busy) begin
                        if (r_iters == r_max_iter) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_iters   <= r_iters + IT_W'(1);
                            r_changed <= 1'b0;
                            r_state   <= ST_A_ISS;
                        end
                    end
                end
                ST_FIN: begin
                    if (!r_p_valid && w_o_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss_valid <= 1'b0;
        end else begin
            r_iss_valid <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_first <= r_dj == '0;
        r_iss_last  <= w_last_dim;
        r_iss_nodim <= w_d == '0;
        r_iss_dim   <= r_dj;
        r_iss_pid   <= r_pi[PID_W-1:0];
    end

    // point and assignment memories
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_req.req_type == REQ_LOAD_P) begin
            r_pmem[{i_req.row_index, i_req.dim_index}] <= i_req.coord_value;
        end
        r_pmem_q <= r_pmem[{r_pi[PID_W-1:0], r_dj}];
    end

    always_ff @(posedge i_clk) begin
        if (w_amem_we) begin
            r_amem[w_tok[MAX_CLUSTERS].pid] <= w_tok[MAX_CLUSTERS].best_id;
        end
        if (w_amem_re) begin
            r_amem_q <= r_amem[w_amem_ra];
        end
    end

    // cell chain
    always_comb begin
        w_ctl.mode = MODE_IDLE;
        if (r_state == ST_A_ISS || r_state == ST_A_DRN) begin
            w_ctl.mode = MODE_DIST;
        end else if (r_state == ST_S_ISS || r_state == ST_S_DRN) begin
            w_ctl.mode = MODE_ACCUM;
        end
        w_ctl.k         = w_k;
        w_ctl.d         = w_d;
        w_ctl.clr_sums  = r_state == ST_A_END;
        w_ctl.div_start = r_state == ST_DIV;
        w_ctl.rd_dim    = i_req.dim_index;
        w_ctl.wr_en     = w_in_acc && i_req.req_type == REQ_LOAD_C && w_row_cent;
        w_ctl.wr_row    = i_req.row_index[CID_W-1:0];
        w_ctl.wr_dim    = i_req.dim_index;
        w_ctl.wr_data   = i_req.coord_value;
    end

    always_comb begin
        w_tok[0].valid   = r_iss_valid;
        w_tok[0].first   = r_iss_first;
        w_tok[0].last    = r_iss_last;
        w_tok[0].nodim   = r_iss_nodim;
        w_tok[0].dim     = r_iss_dim;
        w_tok[0].pid     = r_iss_pid;
        w_tok[0].cid     = (NP_W'(r_iss_pid) < r_fill) ? r_amem_q : '0;
        w_tok[0].coord   = r_pmem_q;
        w_tok[0].best_d  = '0;
        w_tok[0].best_id = '0;
    end

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        kmc_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1]),
            .o_rd_coord (w_rd_coord[g]),
            .o_busy     (w_cell_busy[g])
        );
    end

    // read stage and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_in_acc && w_is_read) begin
            r_p_valid <= 1'b1;
        end else if (r_p_valid && w_o_free) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_read) begin
            r_p_kind <= (i_req.req_type == REQ_READ_C) ? RESP_CENT : RESP_ASSIGN;
            r_p_val  <= w_row_cent ? w_rd_coord[i_req.row_index[CID_W-1:0]] : '0;
            r_p_row  <= i_req.row_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_free) begin
            r_o_valid <= r_p_valid || r_state == ST_FIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_free) begin
            if (r_p_valid) begin
                r_o_kind  <= r_p_kind;
                r_o_val   <= (r_p_kind == RESP_CENT) ? r_p_val : '0;
                r_o_cid   <= (r_p_kind == RESP_ASSIGN && NP_W'(r_p_row) < r_fill)
                             ? r_amem_q : '0;
                r_o_iters <= '0;
                r_o_conv  <= 1'b0;
            end else if (r_state == ST_FIN) begin
                r_o_kind  <= RESP_RUN;
                r_o_val   <= '0;
                r_o_cid   <= '0;
                r_o_iters <= r_iters;
                r_o_conv  <= r_conv;
            end
        end
    end

    assign o_resp.valid          = r_o_valid;
    assign o_resp.resp_kind      = r_o_kind;
    assign o_resp.data_value     = r_o_val;
    assign o_resp.cluster_id     = r_o_cid;
    assign o_resp.iterations_run = r_o_iters;
    assign o_resp.converged      = r_o_conv;

    a_no_accept_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_in_ready)
        else $error("item accepted during a run");

    a_read_stage_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_p_valid)
        else $error("read pending during a run");

    a_assign_write_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_amem_we |-> (r_state == ST_A_ISS || r_state == ST_A_DRN))
        else $error("assignment written outside assignment pass");

    a_run_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !r_p_valid && w_o_free)
        |=> (r_o_valid && r_o_kind == RESP_RUN && r_state == ST_IDLE))
        else $error("run status not delivered");

endmodule
